FILE: rtl/core/tlsd_pkg.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer package
// Shared types and constants for the handshake deframer and its channels.
// ----------------------------------------------------------------------------
package tlsd_pkg;

    localparam int unsigned HDR_BYTES = 4;

    // Input function codes
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_ABORT = 1'b1;

    // Byte kind codes on the result channel
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_NC     = 2'd2;

    localparam logic [24:0] LIMIT_RESET = 25'd16388;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_kind;
        logic        message_end;
        logic [7:0]  message_type;
        logic [23:0] body_length;
        logic [24:0] byte_offset;
        logic        limit_error;
    } t_result;

endpackage

FILE: rtl/core/tlsd_if.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer channel interfaces
// Valid/ready channels for input items, result items and the limit register.
// ----------------------------------------------------------------------------
interface tlsd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, func, in_byte, input ready);
    modport sink   (input valid, func, in_byte, output ready);
endinterface

interface tlsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_kind;
    logic        message_end;
    logic [7:0]  message_type;
    logic [23:0] body_length;
    logic [24:0] byte_offset;
    logic        limit_error;

    modport source (output valid, out_byte, byte_kind, message_end, message_type,
                    body_length, byte_offset, limit_error, input ready);
    modport sink   (input valid, out_byte, byte_kind, message_end, message_type,
                    body_length, byte_offset, limit_error, output ready);
endinterface

interface tlsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/core/tls_handshake_deframer.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer
// Marks header, body and end bytes of a handshake message byte stream.
//
//   Channel  Dir  Carries
//   i_in     in   func, in_byte
//   o_out    out  out_byte, byte_kind, message_end, message_type,
//                 body_length, byte_offset, limit_error
//   i_cfg    in   data (message_limit)
//
// One item is accepted per clock while o_out is not stalled; each result passes
// from the input register through the framing logic into the result register.
// A stall on o_out holds the result register and backs up into the input
// register, so i_in stops only once both are full.
// Reset clears the reader state and sets the limit to 16388 bytes.
// ----------------------------------------------------------------------------
module tls_handshake_deframer
    import tlsd_pkg::*;
#(
    parameter int unsigned MAX_BODY_LENGTH = 16777215
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlsd_in_if.sink    i_in,
    tlsd_out_if.source o_out,
    tlsd_cfg_if.sink   i_cfg
);

    logic [24:0] r_message_limit;
    logic        stage_valid;
    t_in_item    stage_item;
    logic        take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_limit <= LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_message_limit <= i_cfg.data;
        end
    end

    tlsd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    tlsd_frame_core #(
        .MAX_BODY_LENGTH (MAX_BODY_LENGTH)
    ) u_frame_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_item  (stage_item),
        .i_limit (r_message_limit),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/core/tlsd_in_stage.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer input stage
// Registers each accepted input item ahead of the framing logic.
// ----------------------------------------------------------------------------
module tlsd_in_stage
    import tlsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlsd_in_if.sink   i_in,
    input  logic      i_take,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // The stage refills in the same cycle that the framing logic takes its item.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item.func    <= i_in.func;
            r_item.in_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/tlsd_frame_core.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer framing core
// Tracks header and body position, checks the size limit, registers results.
// ----------------------------------------------------------------------------
module tlsd_frame_core
    import tlsd_pkg::*;
#(
    parameter int unsigned MAX_BODY_LENGTH = 16777215
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic [24:0] i_limit,
    output logic        o_take,
    tlsd_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ERROR  = 2'd2
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_hcount, n_hcount;
    logic [7:0]  r_type,   n_type;
    logic [23:0] r_len,    n_len;
    logic [23:0] r_remain, n_remain;
    logic [24:0] r_offset, n_offset;
    t_result     r_res,    n_res;
    logic        r_out_valid;

    logic [23:0] len_new;
    logic [24:0] total;
    logic        oversize;
    logic [23:0] remain_dec;
    logic        body_end;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    assign len_new    = {r_len[15:0], i_item.in_byte};
    assign total      = {1'b0, len_new} + 25'(HDR_BYTES);
    assign oversize   = (len_new > 24'(MAX_BODY_LENGTH)) || (total > i_limit);
    assign remain_dec = (r_remain != '0) ? r_remain - 24'd1 : r_remain;
    assign body_end   = (remain_dec == '0);

    always_comb begin
        n_phase  = r_phase;
        n_hcount = r_hcount;
        n_type   = r_type;
        n_len    = r_len;
        n_remain = r_remain;
        n_offset = r_offset;
        n_res    = '0;
        if (i_item.func == FUNC_ABORT) begin
            n_phase         = PH_HEADER;
            n_hcount        = '0;
            n_type          = '0;
            n_len           = '0;
            n_remain        = '0;
            n_offset        = '0;
            n_res.byte_kind = KIND_NC;
        end else begin
            n_res.out_byte = i_item.in_byte;
            unique case (r_phase)
                PH_ERROR: begin
                    n_res.byte_kind    = KIND_NC;
                    n_res.message_type = r_type;
                    n_res.body_length  = r_len;
                    n_res.limit_error  = 1'b1;
                end
                PH_BODY: begin
                    n_remain           = remain_dec;
                    n_offset           = r_offset + 25'd1;
                    n_res.byte_kind    = KIND_BODY;
                    n_res.message_end  = body_end;
                    n_res.message_type = r_type;
                    n_res.body_length  = r_len;
                    n_res.byte_offset  = r_offset;
                    if (body_end) begin
                        n_phase  = PH_HEADER;
                        n_hcount = '0;
                        n_offset = '0;
                    end
                end
                default: begin
                    // Header phase; the unused phase code behaves the same way.
                    n_res.byte_kind = KIND_HEADER;
                    if (r_hcount == 2'd0) begin
                        n_type             = i_item.in_byte;
                        n_len              = '0;
                        n_hcount           = 2'd1;
                        n_offset           = 25'd1;
                        n_res.message_type = i_item.in_byte;
                    end else if (r_hcount != 2'd3) begin
                        n_len              = len_new;
                        n_hcount           = r_hcount + 2'd1;
                        n_offset           = {23'd0, r_hcount + 2'd1};
                        n_res.message_type = r_type;
                        n_res.byte_offset  = {23'd0, r_hcount};
                    end else begin
                        n_len              = len_new;
                        n_hcount           = '0;
                        n_res.message_type = r_type;
                        n_res.body_length  = len_new;
                        if (oversize) begin
                            n_phase           = PH_ERROR;
                            n_offset          = '0;
                            n_res.byte_kind   = KIND_NC;
                            n_res.limit_error = 1'b1;
                        end else if (len_new == '0) begin
                            n_phase           = PH_HEADER;
                            n_offset          = '0;
                            n_res.message_end = 1'b1;
                            n_res.byte_offset = 25'd3;
                        end else begin
                            n_phase           = PH_BODY;
                            n_remain          = len_new;
                            n_offset          = 25'(HDR_BYTES);
                            n_res.byte_offset = 25'd3;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hcount    <= '0;
            r_type      <= '0;
            r_len       <= '0;
            r_remain    <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase  <= n_phase;
                r_hcount <= n_hcount;
                r_type   <= n_type;
                r_len    <= n_len;
                r_remain <= n_remain;
                r_offset <= n_offset;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.byte_kind    = r_res.byte_kind;
    assign o_out.message_end  = r_res.message_end;
    assign o_out.message_type = r_res.message_type;
    assign o_out.body_length  = r_res.body_length;
    assign o_out.byte_offset  = r_res.byte_offset;
    assign o_out.limit_error  = r_res.limit_error;

endmodule

FILE: rtl/core/tlsd_checker.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tlsd_checker
    import tlsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic [1:0]  i_byte_kind,
    input logic        i_message_end,
    input logic [24:0] i_byte_offset,
    input logic        i_limit_error
);

    // Reset is synchronous, so no result is offered in the cycle after it.
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    // A stalled result must hold.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_byte_offset)
            && $stable(i_byte_kind))
        else $error("stalled result changed");

    // An error result is never consumed and carries no position.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_limit_error |->
            i_byte_kind == KIND_NC && i_byte_offset == '0 && !i_message_end)
        else $error("error result has inconsistent fields");

    // Only a consumed byte can end a message.
    a_end_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_message_end |->
            i_byte_kind == KIND_HEADER || i_byte_kind == KIND_BODY)
        else $error("message end on a byte that was not consumed");

    // Body bytes always follow the four header bytes.
    a_body_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_byte_kind == KIND_BODY |-> i_byte_offset >= 25'(HDR_BYTES))
        else $error("body byte placed inside the header");

endmodule

bind tls_handshake_deframer tlsd_checker u_tlsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_kind   (o_out.byte_kind),
    .i_message_end (o_out.message_end),
    .i_byte_offset (o_out.byte_offset),
    .i_limit_error (o_out.limit_error)
);

FILE: test/tls_handshake_deframer_test.sv
// ----------------------------------------------------------------------------
// TLS handshake deframer testbench
// Streams handshake bytes through the deframer under random back-pressure,
// predicts every marked byte and compares it field by field.
// ----------------------------------------------------------------------------
module tls_handshake_deframer_test;
    import tlsd_pkg::*;

    localparam int unsigned IDLE_LIMIT       = 4000;
    localparam int unsigned LONG_HOLD_AT     = 500;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 6;
    localparam int unsigned MAX_REPORTS      = 40;
    localparam logic [23:0] BODY_LENGTH_MAX  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        RD_HEADER = 2'd0,
        RD_BODY   = 2'd1,
        RD_ERROR  = 2'd2
    } t_read_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlsd_in_if  in_ch();
    tlsd_out_if out_ch();
    tlsd_cfg_if cfg_ch();

    tls_handshake_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted reader state and the limit register as last written
    t_read_phase rd_phase;
    logic [1:0]  hdr_count;
    logic [7:0]  type_hold;
    logic [23:0] len_hold;
    logic [23:0] body_left;
    logic [24:0] msg_off;
    logic [24:0] limit_reg;

    t_in_item    pending_bytes[$];
    t_result     expected_frames[$];

    int unsigned queued_count   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_idle      = 0;
    logic        in_taken       = 1'b0;
    logic        no_idle        = 1'b0;
    logic        long_hold_done = 1'b0;
    t_result     got_frame;
    t_result     want_frame;

    function automatic int unsigned draw_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advances the predicted reader by one item and returns the marked byte.
    function automatic t_result frame_byte(t_in_item item);
        t_result     r;
        logic [23:0] len;
        logic [24:0] total;
        r = '0;
        if (item.func == FUNC_ABORT) begin
            rd_phase  = RD_HEADER;
            hdr_count = 2'd0;
            type_hold = 8'd0;
            len_hold  = 24'd0;
            body_left = 24'd0;
            msg_off   = 25'd0;
            r.byte_kind = KIND_NC;
            return r;
        end
        r.out_byte = item.in_byte;
        case (rd_phase)
            RD_ERROR: begin
                r.byte_kind    = KIND_NC;
                r.message_type = type_hold;
                r.body_length  = len_hold;
                r.limit_error  = 1'b1;
            end
            RD_BODY: begin
                r.byte_kind    = KIND_BODY;
                r.message_type = type_hold;
                r.body_length  = len_hold;
                r.byte_offset  = msg_off;
                if (body_left != 24'd0) body_left = body_left - 24'd1;
                r.message_end = (body_left == 24'd0);
                msg_off = msg_off + 25'd1;
                if (r.message_end) begin
                    rd_phase  = RD_HEADER;
                    hdr_count = 2'd0;
                    msg_off   = 25'd0;
                end
            end
            default: begin
                r.byte_kind = KIND_HEADER;
                case (hdr_count)
                    2'd0: begin
                        type_hold = item.in_byte;
                        len_hold  = 24'd0;
                        hdr_count = 2'd1;
                        msg_off   = 25'd1;
                        r.message_type = item.in_byte;
                    end
                    2'd1, 2'd2: begin
                        r.message_type = type_hold;
                        r.byte_offset  = 25'(hdr_count);
                        len_hold  = {len_hold[15:0], item.in_byte};
                        hdr_count = hdr_count + 2'd1;
                        msg_off   = 25'(hdr_count);
                    end
                    default: begin
                        len   = {len_hold[15:0], item.in_byte};
                        total = {1'b0, len} + 25'(HDR_BYTES);
                        len_hold  = len;
                        hdr_count = 2'd0;
                        r.message_type = type_hold;
                        r.body_length  = len;
                        if (len > BODY_LENGTH_MAX || total > limit_reg) begin
                            rd_phase      = RD_ERROR;
                            msg_off       = 25'd0;
                            r.byte_kind   = KIND_NC;
                            r.limit_error = 1'b1;
                        end else if (len == 24'd0) begin
                            rd_phase      = RD_HEADER;
                            msg_off       = 25'd0;
                            r.message_end = 1'b1;
                            r.byte_offset = 25'd3;
                        end else begin
                            rd_phase      = RD_BODY;
                            body_left     = len;
                            msg_off       = 25'(HDR_BYTES);
                            r.byte_offset = 25'd3;
                        end
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS) $display("MISMATCH %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d: %s is 'h%0h, expected 'h%0h",
                                      results_seen, name, got_v, want_v));
    endtask

    task automatic push_item(logic func, logic [7:0] b);
        t_in_item it;
        it.func    = func;
        it.in_byte = b;
        pending_bytes.push_back(it);
        queued_count++;
    endtask

    // Queues one message. Oversize ones get a few discarded bytes and an abort;
    // bodies longer than body_cap are cut short and aborted.
    task automatic queue_message(logic [7:0] kind_byte, logic [23:0] len,
                                 int unsigned body_cap);
        int unsigned cut;
        push_item(FUNC_DATA, kind_byte);
        push_item(FUNC_DATA, len[23:16]);
        push_item(FUNC_DATA, len[15:8]);
        push_item(FUNC_DATA, len[7:0]);
        if ({1'b0, len} + 25'(HDR_BYTES) > limit_reg) begin
            repeat ($urandom_range(0, 3)) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
            push_item(FUNC_ABORT, 8'($urandom_range(0, 255)));
        end else if (len > 24'(body_cap)) begin
            cut = $urandom_range(0, body_cap);
            repeat (cut) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
            push_item(FUNC_ABORT, 8'($urandom_range(0, 255)));
        end else begin
            repeat (len) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_traffic(int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = queued_count + n_items;
        while (queued_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 56) begin
                queue_message(8'($urandom_range(0, 255)), 24'($urandom_range(0, 12)), 40);
            end else if (pick < 70) begin
                queue_message(8'($urandom_range(0, 255)), 24'($urandom_range(13, 40)), 40);
            end else if (pick < 80) begin
                queue_message(8'($urandom_range(0, 255)),
                              24'($urandom_range(0, 24'hFFFFFF)), 8);
            end else if (pick < 94) begin
                // Header cut short or plain noise, then resynchronise
                repeat ($urandom_range(1, 6)) push_item(FUNC_DATA, 8'($urandom_range(0, 255)));
                push_item(FUNC_ABORT, 8'($urandom_range(0, 255)));
            end else begin
                push_item(FUNC_ABORT, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [24:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        limit_reg = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Input side: an item is taken when valid and ready meet at the edge.
    always @(posedge i_clk) begin
        t_in_item bus_item;
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            bus_item.func    = in_ch.func;
            bus_item.in_byte = in_ch.in_byte;
            expected_frames.push_back(frame_byte(bus_item));
            void'(pending_bytes.pop_front());
            items_accepted++;
            send_gap = draw_gap();
        end
    end

    always @(negedge i_clk) begin
        if (in_ch.valid && !in_taken) begin
            // Offer still open: keep it on the bus.
        end else if (send_gap > 0) begin
            in_ch.valid <= 1'b0;
            send_gap--;
        end else if (pending_bytes.size() > 0) begin
            in_ch.valid   <= 1'b1;
            in_ch.func    <= pending_bytes[0].func;
            in_ch.in_byte <= pending_bytes[0].in_byte;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output side: random stalls, plus one long hold-off to fill the block.
    always @(negedge i_clk) begin
        if (!long_hold_done && items_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            recv_idle      = LONG_HOLD_CYCLES;
        end
        if (recv_idle > 0) begin
            out_ch.ready <= 1'b0;
            recv_idle--;
        end else begin
            out_ch.ready <= 1'b1;
            recv_idle = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_frame.out_byte     = out_ch.out_byte;
            got_frame.byte_kind    = out_ch.byte_kind;
            got_frame.message_end  = out_ch.message_end;
            got_frame.message_type = out_ch.message_type;
            got_frame.body_length  = out_ch.body_length;
            got_frame.byte_offset  = out_ch.byte_offset;
            got_frame.limit_error  = out_ch.limit_error;
            if (expected_frames.size() == 0) begin
                report_mismatch($sformatf("result %0d: no item outstanding", results_seen));
            end else begin
                want_frame = expected_frames.pop_front();
                check_field("out_byte", 32'(got_frame.out_byte),
                            32'(want_frame.out_byte));
                check_field("byte_kind", 32'(got_frame.byte_kind),
                            32'(want_frame.byte_kind));
                check_field("message_end", 32'(got_frame.message_end),
                            32'(want_frame.message_end));
                check_field("message_type", 32'(got_frame.message_type),
                            32'(want_frame.message_type));
                check_field("body_length", 32'(got_frame.body_length),
                            32'(want_frame.body_length));
                check_field("byte_offset", 32'(got_frame.byte_offset),
                            32'(want_frame.byte_offset));
                check_field("limit_error", 32'(got_frame.limit_error),
                            32'(want_frame.limit_error));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tls_handshake_deframer_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [24:0] phase_limits [7];
        int unsigned phase_items  [7];
        int unsigned ph;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_DATA;
        in_ch.in_byte = 8'd0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 25'd0;

        rd_phase  = RD_HEADER;
        hdr_count = 2'd0;
        type_hold = 8'd0;
        len_hold  = 24'd0;
        body_left = 24'd0;
        msg_off   = 25'd0;
        limit_reg = LIMIT_RESET;

        phase_limits = '{25'd4, 25'd0, 25'd24, LIMIT_RESET, 25'd16777219,
                         25'h1FFFFFF, 25'd4};
        phase_items  = '{180, 60, 180, 180, 200, 200, 180};
        phase_limits[6] = 25'($urandom_range(4, 64));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset limit.
        // Zero-length body: the fourth header byte ends the message.
        queue_message(8'hFF, 24'd0, 40);
        queue_message(8'h00, 24'd2, 40);
        // Largest declared body, far over the limit: error phase, then abort.
        push_item(FUNC_DATA, 8'h01);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_DATA, 8'h80);
        push_item(FUNC_DATA, 8'h7F);
        push_item(FUNC_ABORT, 8'hFF);
        // Exactly at the limit is accepted; abort part way into the body.
        push_item(FUNC_DATA, 8'h02);
        push_item(FUNC_DATA, 8'h00);
        push_item(FUNC_DATA, 8'h40);
        push_item(FUNC_DATA, 8'h00);
        push_item(FUNC_DATA, 8'hA5);
        push_item(FUNC_ABORT, 8'h00);
        // Abort inside the header.
        push_item(FUNC_DATA, 8'h03);
        push_item(FUNC_DATA, 8'h00);
        push_item(FUNC_ABORT, 8'h5A);
        wait_drained();

        for (ph = 0; ph < 7; ph++) begin
            write_limit(phase_limits[ph]);
            no_idle = (ph == 3);
            queue_traffic(phase_items[ph]);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("tls_handshake_deframer_test: PASS");
        end else begin
            $display("tls_handshake_deframer_test: FAIL");
        end
        $finish;
    end

endmodule
